// File: hdl/cfcp_pkg.sv
// Shared types and constants for the class file constant pool parser.
`timescale 1ns / 1ps
`default_nettype none
package cfcp_pkg;

	typedef enum logic [10:0] {
		PH_MAGIC = 11'b000_0000_0001,
		PH_MINOR = 11'b000_0000_0010,
		PH_MAJOR = 11'b000_0000_0100,
		PH_COUNT = 11'b000_0000_1000,
		PH_TAG   = 11'b000_0001_0000,
		PH_TLEN  = 11'b000_0010_0000,
		PH_TCHR  = 11'b000_0100_0000,
		PH_IDXA  = 11'b000_1000_0000,
		PH_IDXB  = 11'b001_0000_0000,
		PH_HALT  = 11'b010_0000_0000,
		PH_DONE  = 11'b100_0000_0000
	} phase_t;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_ENTRY  = 2'd1;
	localparam logic [1:0] KIND_CHAR   = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam logic [7:0] TAG_UTF8     = 8'h01;
	localparam logic [7:0] TAG_CLASS    = 8'h07;
	localparam logic [7:0] TAG_STRING   = 8'h08;
	localparam logic [7:0] TAG_FIELD    = 8'h09;
	localparam logic [7:0] TAG_METHOD   = 8'h0A;
	localparam logic [7:0] TAG_NAMETYPE = 8'h0C;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  bif;
		logic [31:0] magic;
		logic [15:0] minor;
		logic [15:0] major;
		logic [15:0] count;
		logic [15:0] done;
		logic [7:0]  tag;
		logic [15:0] idx_a;
		logic [15:0] idx_b;
		logic [15:0] len;
		logic [15:0] left;
	} parse_st_t;

	localparam parse_st_t ST_RESET = '{
		phase: PH_MAGIC, bif: 2'd0, magic: 32'd0, minor: 16'd0, major: 16'd0,
		count: 16'd0, done: 16'd0, tag: 8'd0, idx_a: 16'd0, idx_b: 16'd0,
		len: 16'd0, left: 16'd0
	};

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] magic;
		logic [15:0] minor;
		logic [15:0] major;
		logic [15:0] count;
		logic [7:0]  tag;
		logic [15:0] first;
		logic [15:0] second;
		logic [15:0] length;
		logic [7:0]  chr;
		logic        last;
		logic [15:0] number;
	} rec_t;

endpackage
`default_nettype wire

// File: hdl/cfcp_parse_core.sv
// Parse state registers and the per-byte next-state and record logic.
`timescale 1ns / 1ps
`default_nettype none
module cfcp_parse_core (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              en,
	input  wire [7:0]        data_byte,
	input  wire              start_file,
	output cfcp_pkg::rec_t   rec,
	output logic             rec_valid
);
	import cfcp_pkg::*;

	parse_st_t st_q;
	parse_st_t cur;
	parse_st_t nxt;
	logic        fin;
	logic [7:0]  fin_ch;
	logic        err;
	logic        chr;
	logic        hdr;
	logic        last;
	logic [15:0] total;

	always_comb begin
		cur = start_file ? ST_RESET : st_q;
		nxt = cur;
		fin = 1'b0;
		fin_ch = 8'd0;
		err = 1'b0;
		chr = 1'b0;
		hdr = 1'b0;
		case (cur.phase)
			PH_MAGIC: begin
				nxt.magic = {cur.magic[23:0], data_byte};
				if (cur.bif == 2'd3) begin
					nxt.bif = 2'd0;
					nxt.phase = PH_MINOR;
				end else begin
					nxt.bif = cur.bif + 2'd1;
				end
			end
			PH_MINOR: begin
				nxt.minor = {cur.minor[7:0], data_byte};
				if (cur.bif == 2'd1) begin
					nxt.bif = 2'd0;
					nxt.phase = PH_MAJOR;
				end else begin
					nxt.bif = 2'd1;
				end
			end
			PH_MAJOR: begin
				nxt.major = {cur.major[7:0], data_byte};
				if (cur.bif == 2'd1) begin
					nxt.bif = 2'd0;
					nxt.phase = PH_COUNT;
				end else begin
					nxt.bif = 2'd1;
				end
			end
			PH_COUNT: begin
				nxt.count = {cur.count[7:0], data_byte};
				if (cur.bif == 2'd0) begin
					nxt.bif = 2'd1;
				end else begin
					nxt.bif = 2'd0;
					nxt.done = 16'd0;
					hdr = 1'b1;
					// a count of zero or one leaves the pool empty
					nxt.phase = (nxt.count <= 16'd1) ? PH_DONE : PH_TAG;
				end
			end
			PH_TAG: begin
				nxt.tag = data_byte;
				nxt.idx_a = 16'd0;
				nxt.idx_b = 16'd0;
				nxt.len = 16'd0;
				nxt.left = 16'd0;
				nxt.bif = 2'd0;
				if (data_byte == TAG_UTF8) begin
					nxt.phase = PH_TLEN;
				end else if (data_byte == TAG_CLASS || data_byte == TAG_STRING ||
						data_byte == TAG_FIELD || data_byte == TAG_METHOD ||
						data_byte == TAG_NAMETYPE) begin
					nxt.phase = PH_IDXA;
				end else begin
					err = 1'b1;
					nxt.phase = PH_HALT;
				end
			end
			PH_TLEN: begin
				nxt.len = {cur.len[7:0], data_byte};
				if (cur.bif == 2'd0) begin
					nxt.bif = 2'd1;
				end else begin
					nxt.bif = 2'd0;
					nxt.left = nxt.len;
					if (nxt.len == 16'd0) fin = 1'b1;
					else nxt.phase = PH_TCHR;
				end
			end
			PH_TCHR: begin
				nxt.left = cur.left - 16'd1;
				if (nxt.left == 16'd0) begin
					fin = 1'b1;
					fin_ch = data_byte;
				end else begin
					chr = 1'b1;
				end
			end
			PH_IDXA: begin
				nxt.idx_a = {cur.idx_a[7:0], data_byte};
				if (cur.bif == 2'd0) begin
					nxt.bif = 2'd1;
				end else begin
					nxt.bif = 2'd0;
					if (cur.tag == TAG_CLASS || cur.tag == TAG_STRING) fin = 1'b1;
					else nxt.phase = PH_IDXB;
				end
			end
			PH_IDXB: begin
				nxt.idx_b = {cur.idx_b[7:0], data_byte};
				if (cur.bif == 2'd0) nxt.bif = 2'd1;
				else fin = 1'b1;
			end
			default: begin
				// halted after an error or past the pool: drop the byte
			end
		endcase

		total = (cur.count == 16'd0) ? 16'd0 : cur.count - 16'd1;
		last = ({1'b0, cur.done} + 17'd1) >= {1'b0, total};

		rec = '0;
		rec_valid = hdr | fin | err | chr;
		if (hdr) begin
			rec.kind = KIND_HEADER;
			rec.magic = nxt.magic;
			rec.minor = nxt.minor;
			rec.major = nxt.major;
			rec.count = nxt.count;
			rec.last = (nxt.count <= 16'd1);
		end else begin
			rec.tag = nxt.tag;
			rec.number = cur.done;
			if (!err) begin
				rec.first = nxt.idx_a;
				rec.second = nxt.idx_b;
				rec.length = nxt.len;
			end
			if (err) begin
				rec.kind = KIND_ERROR;
			end else if (chr) begin
				rec.kind = KIND_CHAR;
				rec.chr = data_byte;
			end else begin
				rec.kind = KIND_ENTRY;
				rec.chr = fin_ch;
				rec.last = last;
			end
		end
		if (fin) begin
			nxt.done = cur.done + 16'd1;
			nxt.phase = last ? PH_DONE : PH_TAG;
			nxt.bif = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (en) begin
			st_q <= nxt;
		end
	end

endmodule
`default_nettype wire

// File: hdl/class_file_constant_pool_parser.sv
// Top level: input register, parse core and result register.
//
//  channel | handshake            | payload
//  input   | in_valid / in_ready  | data_byte, start_file
//  output  | out_valid / out_ready| record_kind .. entry_number (zero or one per byte)
//
// One byte is taken per cycle while the input register is free or advancing; a
// byte's record passes through the input register and then the result register
// around the core before it appears on the outputs.
// Reset returns the parser to waiting for the magic number; start_file does the
// same for the byte that carries it.
// A stalled result holds in the output register; the input side keeps moving as
// long as that register is free or being emptied in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module class_file_constant_pool_parser (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  data_byte,
	input  wire         start_file,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  record_kind,
	output logic [31:0] magic_word,
	output logic [15:0] minor_version,
	output logic [15:0] major_version,
	output logic [15:0] pool_count,
	output logic [7:0]  entry_tag,
	output logic [15:0] first_index,
	output logic [15:0] second_index,
	output logic [15:0] text_length,
	output logic [7:0]  text_char,
	output logic        last_entry,
	output logic [15:0] entry_number
);
	import cfcp_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       start_s1;
	logic       advance;
	rec_t       rec;
	logic       rec_valid;
	rec_t       rec_q;
	logic       out_valid_q;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= data_byte;
			start_s1 <= start_file;
		end
	end

	cfcp_parse_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (valid_s1 && advance),
		.data_byte  (data_s1),
		.start_file (start_s1),
		.rec        (rec),
		.rec_valid  (rec_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && rec_valid;
		end
	end

	// hold the record while downstream stalls
	always_ff @(posedge clk) begin
		if (advance && valid_s1 && rec_valid) begin
			rec_q <= rec;
		end
	end

	assign out_valid     = out_valid_q;
	assign record_kind   = rec_q.kind;
	assign magic_word    = rec_q.magic;
	assign minor_version = rec_q.minor;
	assign major_version = rec_q.major;
	assign pool_count    = rec_q.count;
	assign entry_tag     = rec_q.tag;
	assign first_index   = rec_q.first;
	assign second_index  = rec_q.second;
	assign text_length   = rec_q.length;
	assign text_char     = rec_q.chr;
	assign last_entry    = rec_q.last;
	assign entry_number  = rec_q.number;

endmodule
`default_nettype wire
